/* hw/rtl/csvfs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvfs_pkg
// Shared types and character codes for the CSV field splitter.
// ---------------------------------------------------------------------------
package csvfs_pkg;

  // Character codes that steer the parser
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Input request mode
  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_EOL  = 1'b1
  } mode_t;

  // Result kind
  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // One input request as held in the input register
  typedef struct packed {
    mode_t      mode;
    logic [7:0] byte_value;
  } item_t;

  // One result request
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       ends_line;
  } result_t;

endpackage

/* hw/rtl/csvfs_parse.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvfs_parse
// Quote state and per-byte decode: turns one held request into zero or one
// result and advances the three state bits when the request retires.
// ---------------------------------------------------------------------------
module csvfs_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  csvfs_pkg::item_t item,
  input  logic             retire,
  output logic             emit,
  output csvfs_pkg::result_t result
);
  import csvfs_pkg::*;

  logic in_quotes_r, in_quotes_nxt;
  logic quote_pending_r, quote_pending_nxt;
  logic has_chars_r, has_chars_nxt;
  logic outside;

  // Decode the held byte against the current quote state
  always_comb begin
    in_quotes_nxt     = in_quotes_r;
    quote_pending_nxt = quote_pending_r;
    has_chars_nxt     = has_chars_r;
    emit              = 1'b0;
    result            = '{kind: KIND_CHAR, ch: 8'h00, ends_line: 1'b0};
    outside           = 1'b0;

    if (item.mode == MODE_EOL) begin
      // close the line: final field end, clear everything
      in_quotes_nxt     = 1'b0;
      quote_pending_nxt = 1'b0;
      has_chars_nxt     = 1'b0;
      emit              = 1'b1;
      result            = '{kind: KIND_END, ch: 8'h00, ends_line: 1'b1};
    end else begin
      if (quote_pending_r) begin
        // resolve the pending quote: doubled quote or close
        quote_pending_nxt = 1'b0;
        if (item.byte_value == CH_QUOTE) begin
          in_quotes_nxt = 1'b1;
          has_chars_nxt = 1'b1;
          emit          = 1'b1;
          result        = '{kind: KIND_CHAR, ch: CH_QUOTE, ends_line: 1'b0};
        end else begin
          in_quotes_nxt = 1'b0;
          outside       = 1'b1;
        end
      end else if (in_quotes_r) begin
        // quoted data; a quote waits for the next byte
        if (item.byte_value == CH_QUOTE) begin
          quote_pending_nxt = 1'b1;
        end else begin
          has_chars_nxt = 1'b1;
          emit          = 1'b1;
          result        = '{kind: KIND_CHAR, ch: item.byte_value, ends_line: 1'b0};
        end
      end else begin
        outside = 1'b1;
      end

      if (outside) begin
        // unquoted handling: open quote, field end, drop CR, or data
        if (item.byte_value == CH_QUOTE && !has_chars_r) begin
          in_quotes_nxt = 1'b1;
        end else if (item.byte_value == CH_COMMA) begin
          has_chars_nxt = 1'b0;
          emit          = 1'b1;
          result        = '{kind: KIND_END, ch: 8'h00, ends_line: 1'b0};
        end else if (item.byte_value != CH_CR) begin
          has_chars_nxt = 1'b1;
          emit          = 1'b1;
          result        = '{kind: KIND_CHAR, ch: item.byte_value, ends_line: 1'b0};
        end
      end
    end
  end

  // Advance the state when the request leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r     <= 1'b0;
      quote_pending_r <= 1'b0;
      has_chars_r     <= 1'b0;
    end else if (retire) begin
      in_quotes_r     <= in_quotes_nxt;
      quote_pending_r <= quote_pending_nxt;
      has_chars_r     <= has_chars_nxt;
    end
  end

`ifndef SYNTHESIS
  // A pending quote only exists inside a quoted field
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    quote_pending_r |-> in_quotes_r)
    else $error("quote pending outside quotes");

  // End of line leaves the parser fully cleared
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    retire && item.mode == MODE_EOL |=> !in_quotes_r && !quote_pending_r && !has_chars_r)
    else $error("state not cleared after end of line");

  // A field end always empties the current field
  a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    retire && emit && result.kind == KIND_END |=> !has_chars_r)
    else $error("field not empty after field end");

  // A character result always marks the field non-empty
  a_char_fills: assert property (@(posedge clk) disable iff (!rst_n)
    retire && emit && result.kind == KIND_CHAR |=> has_chars_r)
    else $error("field empty after character");
`endif

endmodule

/* hw/rtl/csvfs_out_reg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csvfs_out_reg
// Result register: holds one result request until the consumer takes it.
// ---------------------------------------------------------------------------
module csvfs_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  csvfs_pkg::result_t load_data,
  input  logic               out_stall,
  output logic               free,
  output logic               out_valid,
  output csvfs_pkg::result_t out_data
);
  import csvfs_pkg::*;

  logic    valid_r;
  result_t data_r;

  // Room for a new result when empty or being taken this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Hold, take or drop the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= load_data;
    end
  end

endmodule

/* hw/rtl/csv_field_splitter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV line, one byte per request, into field characters and
// field ends, with quoting and doubled-quote escapes.
//
//   channel  ports                                    direction
//   in       in_valid, in_stall, in_mode, in_byte_value   into block
//   out      out_valid, out_stall, out_kind, out_char,
//            out_ends_line                            out of block
//
// One request per cycle while the result register can take results; a result
// passes from the input register through the decode into the result register,
// where it waits until the consumer takes it.
// Requests that yield no result retire without touching the output.
// Synchronous active-low reset clears the quote state and both valids.
// out_stall holds the result register; in_stall rises only when the held
// request has a result and the result register cannot take it.
// ---------------------------------------------------------------------------
module csv_field_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_char,
  output logic       out_ends_line
);
  import csvfs_pkg::*;

  logic    held_valid_r;
  item_t   held_r;
  logic    emit;
  result_t result;
  logic    out_free;
  logic    retire;
  logic    accept;
  result_t out_data;

  // Held request retires unless its result is blocked
  assign retire   = held_valid_r && (!emit || out_free);
  assign in_stall = held_valid_r && !retire;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (!in_stall) begin
      held_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= '{mode: mode_t'(in_mode), byte_value: in_byte_value};
    end
  end

  csvfs_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (held_r),
    .retire (retire),
    .emit   (emit),
    .result (result)
  );

  csvfs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (held_valid_r && emit),
    .load_data (result),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Drive result ports
  assign out_kind      = out_data.kind;
  assign out_char      = out_data.ch;
  assign out_ends_line = out_data.ends_line;

endmodule
